[sv/gbbc_pkg.sv]
// Shared types and constants of the grid bucket best corner block.
package gbbc_pkg;

  localparam int unsigned PYR_LEVELS = 4;
  localparam int unsigned QDEPTH     = 2;

  localparam logic [7:0] CFG_CELL_PIXELS     = 8'd0;
  localparam logic [7:0] CFG_GRID_COLUMNS    = 8'd1;
  localparam logic [7:0] CFG_GRID_ROWS_USED  = 8'd2;
  localparam logic [7:0] CFG_SCORE_THRESHOLD = 8'd3;

  localparam logic [7:0]  RST_CELL_PIXELS     = 8'd30;
  localparam logic [3:0]  RST_GRID_COLUMNS    = 4'd8;
  localparam logic [3:0]  RST_GRID_ROWS_USED  = 4'd8;
  localparam logic [31:0] RST_SCORE_THRESHOLD = 32'd12800;

  typedef enum logic [1:0] {
    FUNC_FLAG   = 2'd0,
    FUNC_CAND   = 2'd1,
    FUNC_FINISH = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_FLAG   = 2'd0,
    KIND_CAND   = 2'd1,
    KIND_FINISH = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [14:0] full_x;
    logic [14:0] full_y;
    logic [1:0]  level;
    logic [31:0] score;
  } item_t;

  typedef struct packed {
    logic [7:0]  cell_pixels;
    logic [3:0]  grid_columns;
    logic [3:0]  grid_rows_used;
    logic [31:0] score_threshold;
  } cfg_t;

  typedef struct packed {
    logic [31:0] score;
    logic [14:0] full_x;
    logic [14:0] full_y;
    logic [1:0]  level;
  } cell_rec_t;

  typedef struct packed {
    logic        found;
    logic [5:0]  cell_number;
    logic [14:0] full_x;
    logic [14:0] full_y;
    logic [1:0]  best_level;
    logic [31:0] best_score;
    logic        last;
  } result_t;

endpackage

[sv/gbbc_front.sv]
// Front part: accepts requests, classifies them and queues them for the back part.
module gbbc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      func_i,
  input  logic [11:0]     pos_x_i,
  input  logic [11:0]     pos_y_i,
  input  logic [1:0]      pyr_level_i,
  input  logic [31:0]     corner_score_i,
  output logic            item_valid_o,
  output gbbc_pkg::item_t item_o,
  input  logic            item_pop_i
);
  import gbbc_pkg::*;

  localparam int unsigned PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CntW = $clog2(QDEPTH + 1);

  item_t            q_mem [QDEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  item_t            item_c;
  logic             keep;
  logic             push, pop;

  always_comb begin
    keep          = 1'b0;
    item_c.kind   = KIND_FLAG;
    item_c.level  = pyr_level_i;
    item_c.score  = corner_score_i;
    item_c.full_x = 15'(pos_x_i);
    item_c.full_y = 15'(pos_y_i);
    unique case (func_e'(func_i))
      FUNC_FLAG: begin
        keep = 1'b1;
      end
      FUNC_CAND: begin
        keep          = ({1'b0, pyr_level_i} < 3'(PYR_LEVELS));
        item_c.kind   = KIND_CAND;
        item_c.full_x = 15'(pos_x_i) << pyr_level_i;
        item_c.full_y = 15'(pos_y_i) << pyr_level_i;
      end
      FUNC_FINISH: begin
        keep        = 1'b1;
        item_c.kind = KIND_FINISH;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall_o   = (count_q == CntW'(QDEPTH));
  assign push         = in_valid_i && !in_stall_o && keep;
  assign item_valid_o = (count_q != '0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= item_c;
    end
  end

endmodule

[sv/gbbc_back.sv]
// Back part: cell lookup by repeated subtraction, best corner update and finish scan.
module gbbc_back #(
  parameter int unsigned MAX_CELLS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gbbc_pkg::cfg_t    cfg_i,
  input  logic              item_valid_i,
  input  gbbc_pkg::item_t   item_i,
  output logic              item_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output gbbc_pkg::result_t result_o
);
  import gbbc_pkg::*;

  localparam int unsigned CellW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_DIV      = 7'b0000010,
    ST_LOOK     = 7'b0000100,
    ST_UPD      = 7'b0001000,
    ST_SCAN_RD  = 7'b0010000,
    ST_SCAN_CHK = 7'b0100000,
    ST_SCAN_END = 7'b1000000
  } state_e;

  state_e               state_q, state_d;
  item_t                item_q, item_d;
  logic [14:0]          rem_x_q, rem_x_d, rem_y_q, rem_y_d;
  logic [3:0]           cnt_x_q, cnt_x_d, cnt_y_q, cnt_y_d;
  logic [CellW-1:0]     k_q, k_d;
  logic [CellW-1:0]     scan_i_q, scan_i_d;
  logic                 held_q, held_d;
  cell_rec_t            held_rec_q, held_rec_d;
  logic [CellW-1:0]     held_cell_q, held_cell_d;
  logic                 out_valid_q, out_valid_d;
  result_t              out_q, out_d;
  logic [MAX_CELLS-1:0] occupied_q, occupied_d;
  logic [MAX_CELLS-1:0] cell_valid_q, cell_valid_d;

  cell_rec_t            mem_q [MAX_CELLS];
  cell_rec_t            rd_q;
  cell_rec_t            new_rec;
  logic                 wr_en;
  logic [CellW-1:0]     wr_addr, rd_addr;

  logic [14:0]          cp15;
  logic                 step_x, step_y;
  logic [7:0]           k_full;
  logic [CellW-1:0]     k_cell;
  logic                 cell_ok;
  logic                 out_free, push_out, hit, last_cell, advance;

  assign cp15      = 15'(cfg_i.cell_pixels);
  assign step_x    = (rem_x_q >= cp15) && (cnt_x_q < cfg_i.grid_columns);
  assign step_y    = (rem_y_q >= cp15) && (cnt_y_q < cfg_i.grid_rows_used);
  assign k_full    = 8'(cnt_y_q) * 8'(cfg_i.grid_columns) + 8'(cnt_x_q);
  assign k_cell    = k_full[CellW-1:0];
  assign cell_ok   = (cnt_x_q < cfg_i.grid_columns) && (cnt_y_q < cfg_i.grid_rows_used)
                     && (k_full < 8'(MAX_CELLS));
  assign out_free  = !out_valid_q || !out_stall_i;
  assign hit       = cell_valid_q[scan_i_q] && (rd_q.score > cfg_i.score_threshold);
  assign last_cell = (scan_i_q == CellW'(MAX_CELLS - 1));

  assign new_rec.score  = item_q.score;
  assign new_rec.full_x = item_q.full_x;
  assign new_rec.full_y = item_q.full_y;
  assign new_rec.level  = item_q.level;

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    rem_x_d      = rem_x_q;
    rem_y_d      = rem_y_q;
    cnt_x_d      = cnt_x_q;
    cnt_y_d      = cnt_y_q;
    k_d          = k_q;
    scan_i_d     = scan_i_q;
    held_d       = held_q;
    held_rec_d   = held_rec_q;
    held_cell_d  = held_cell_q;
    occupied_d   = occupied_q;
    cell_valid_d = cell_valid_q;
    item_pop_o   = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = k_cell;
    rd_addr      = scan_i_q;
    push_out     = 1'b0;
    out_d        = out_q;
    advance      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          item_d     = item_i;
          rem_x_d    = item_i.full_x;
          rem_y_d    = item_i.full_y;
          cnt_x_d    = '0;
          cnt_y_d    = '0;
          if (item_i.kind == KIND_FINISH) begin
            scan_i_d = '0;
            held_d   = 1'b0;
            state_d  = ST_SCAN_RD;
          end else if (cfg_i.cell_pixels != '0) begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (step_x) begin
          rem_x_d = rem_x_q - cp15;
          cnt_x_d = cnt_x_q + 1'b1;
        end
        if (step_y) begin
          rem_y_d = rem_y_q - cp15;
          cnt_y_d = cnt_y_q + 1'b1;
        end
        if (!step_x && !step_y) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        rd_addr = k_cell;
        k_d     = k_cell;
        state_d = ST_IDLE;
        if (cell_ok) begin
          if (item_q.kind == KIND_FLAG) begin
            occupied_d[k_cell] = 1'b1;
          end else if (!occupied_q[k_cell] && (item_q.score > cfg_i.score_threshold)) begin
            if (cell_valid_q[k_cell]) begin
              state_d = ST_UPD;
            end else begin
              wr_en                = 1'b1;
              cell_valid_d[k_cell] = 1'b1;
            end
          end
        end
      end
      ST_UPD: begin
        rd_addr = k_q;
        wr_addr = k_q;
        if (item_q.score > rd_q.score) begin
          wr_en = 1'b1;
        end
        state_d = ST_IDLE;
      end
      ST_SCAN_RD: begin
        state_d = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (hit) begin
          if (held_q) begin
            if (out_free) begin
              push_out          = 1'b1;
              out_d.found       = 1'b1;
              out_d.cell_number = 6'(held_cell_q);
              out_d.full_x      = held_rec_q.full_x;
              out_d.full_y      = held_rec_q.full_y;
              out_d.best_level  = held_rec_q.level;
              out_d.best_score  = held_rec_q.score;
              out_d.last        = 1'b0;
              held_rec_d        = rd_q;
              held_cell_d       = scan_i_q;
              advance           = 1'b1;
            end
          end else begin
            held_d      = 1'b1;
            held_rec_d  = rd_q;
            held_cell_d = scan_i_q;
            advance     = 1'b1;
          end
        end else begin
          advance = 1'b1;
        end
        if (advance) begin
          if (last_cell) begin
            state_d = ST_SCAN_END;
          end else begin
            scan_i_d = scan_i_q + 1'b1;
            state_d  = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_END: begin
        if (out_free) begin
          push_out          = 1'b1;
          out_d.found       = held_q;
          out_d.cell_number = held_q ? 6'(held_cell_q) : '0;
          out_d.full_x      = held_q ? held_rec_q.full_x : '0;
          out_d.full_y      = held_q ? held_rec_q.full_y : '0;
          out_d.best_level  = held_q ? held_rec_q.level : '0;
          out_d.best_score  = held_q ? held_rec_q.score : '0;
          out_d.last        = 1'b1;
          held_d            = 1'b0;
          occupied_d        = '0;
          cell_valid_d      = '0;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = out_valid_q && out_stall_i;
    if (push_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      held_q       <= 1'b0;
      scan_i_q     <= '0;
      out_valid_q  <= 1'b0;
      occupied_q   <= '0;
      cell_valid_q <= '0;
    end else begin
      state_q      <= state_d;
      held_q       <= held_d;
      scan_i_q     <= scan_i_d;
      out_valid_q  <= out_valid_d;
      occupied_q   <= occupied_d;
      cell_valid_q <= cell_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    rem_x_q     <= rem_x_d;
    rem_y_q     <= rem_y_d;
    cnt_x_q     <= cnt_x_d;
    cnt_y_q     <= cnt_y_d;
    k_q         <= k_d;
    held_rec_q  <= held_rec_d;
    held_cell_q <= held_cell_d;
    out_q       <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= new_rec;
    end
    rd_q <= mem_q[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

[sv/grid_bucket_best_corner.sv]
// Top level of the grid bucket best corner block: configuration registers and the two parts.
// Requests enter on in_valid_i/in_stall_o with func_i, pos_x_i, pos_y_i, pyr_level_i and
// corner_score_i; a request is taken at a clock edge where in_valid_i is high and
// in_stall_o is low. A two-entry queue decouples the input from the processing part, so
// requests are taken while it is busy or a result waits at the output until the queue fills.
// A flag or candidate request finds its cell by repeated subtraction of the cell size,
// one step per cycle for column and row together, then updates the cell.
// A finish request scans all MAX_CELLS cells through the registered read of the cell
// memory and emits each qualifying cell in increasing order with last set on the final
// one, or one empty result with found low; it then clears all cells.
// Results leave on out_valid_o/out_stall_i from an output register; while out_stall_i is
// high the result holds and the scan waits.
// Configuration writes use cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i and are
// always ready; the user must make them only while idle, as the block does not enforce it.
// After reset, all cells are empty and unoccupied and the registers hold their defaults.
module grid_bucket_best_corner #(
  parameter int unsigned MAX_CELLS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [11:0] pos_x_i,
  input  logic [11:0] pos_y_i,
  input  logic [1:0]  pyr_level_i,
  input  logic [31:0] corner_score_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [5:0]  cell_number_o,
  output logic [14:0] full_x_o,
  output logic [14:0] full_y_o,
  output logic [1:0]  best_level_o,
  output logic [31:0] best_score_o,
  output logic        last_o
);
  import gbbc_pkg::*;

  cfg_t    cfg_q;
  item_t   item;
  logic    item_valid, item_pop;
  result_t result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cell_pixels     <= RST_CELL_PIXELS;
      cfg_q.grid_columns    <= RST_GRID_COLUMNS;
      cfg_q.grid_rows_used  <= RST_GRID_ROWS_USED;
      cfg_q.score_threshold <= RST_SCORE_THRESHOLD;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CELL_PIXELS:     cfg_q.cell_pixels     <= cfg_data_i[7:0];
        CFG_GRID_COLUMNS:    cfg_q.grid_columns    <= cfg_data_i[3:0];
        CFG_GRID_ROWS_USED:  cfg_q.grid_rows_used  <= cfg_data_i[3:0];
        CFG_SCORE_THRESHOLD: cfg_q.score_threshold <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  gbbc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pyr_level_i    (pyr_level_i),
    .corner_score_i (corner_score_i),
    .item_valid_o   (item_valid),
    .item_o         (item),
    .item_pop_i     (item_pop)
  );

  gbbc_back #(
    .MAX_CELLS (MAX_CELLS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (result)
  );

  assign found_o       = result.found;
  assign cell_number_o = result.cell_number;
  assign full_x_o      = result.full_x;
  assign full_y_o      = result.full_y;
  assign best_level_o  = result.best_level;
  assign best_score_o  = result.best_score;
  assign last_o        = result.last;

endmodule

[tb/gbbc_checker.sv]
// Checker for the grid bucket best corner block: predicts finish results and compares them.
module gbbc_checker #(
  parameter int unsigned MAX_CELLS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  func_i,
  input  logic [11:0] pos_x_i,
  input  logic [11:0] pos_y_i,
  input  logic [1:0]  pyr_level_i,
  input  logic [31:0] corner_score_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        found_i,
  input  logic [5:0]  cell_number_i,
  input  logic [14:0] full_x_i,
  input  logic [14:0] full_y_i,
  input  logic [1:0]  best_level_i,
  input  logic [31:0] best_score_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import gbbc_pkg::*;

  cfg_t      regs;
  logic      occupied  [MAX_CELLS];
  logic      has_best  [MAX_CELLS];
  cell_rec_t best_rec  [MAX_CELLS];
  result_t   finish_q  [$];
  int        fails;

  function automatic int cell_of(logic [14:0] fx, logic [14:0] fy);
    int unsigned col;
    int unsigned row;
    int unsigned k;
    if (regs.cell_pixels == 8'd0) return -1;
    col = fx / regs.cell_pixels;
    row = fy / regs.cell_pixels;
    if (col >= regs.grid_columns || row >= regs.grid_rows_used) return -1;
    k = row * regs.grid_columns + col;
    if (k >= MAX_CELLS) return -1;
    return int'(k);
  endfunction

  task automatic take_request(logic [1:0] f, logic [11:0] px, logic [11:0] py,
                              logic [1:0] lvl, logic [31:0] score);
    int        k;
    int        last_k;
    logic [14:0] fx;
    logic [14:0] fy;
    result_t   r;
    case (func_e'(f))
      FUNC_FLAG: begin
        k = cell_of({3'b000, px}, {3'b000, py});
        if (k >= 0) occupied[k] = 1'b1;
      end
      FUNC_CAND: begin
        fx = {3'b000, px} << lvl;
        fy = {3'b000, py} << lvl;
        k = cell_of(fx, fy);
        if (lvl < PYR_LEVELS && k >= 0 && !occupied[k] && score > regs.score_threshold &&
            !(has_best[k] && score <= best_rec[k].score)) begin
          has_best[k] = 1'b1;
          best_rec[k].score = score;
          best_rec[k].full_x = fx;
          best_rec[k].full_y = fy;
          best_rec[k].level = lvl;
        end
      end
      FUNC_FINISH: begin
        last_k = -1;
        for (int i = 0; i < MAX_CELLS; i++) begin
          if (has_best[i] && best_rec[i].score > regs.score_threshold) last_k = i;
        end
        for (int i = 0; i < MAX_CELLS; i++) begin
          if (has_best[i] && best_rec[i].score > regs.score_threshold) begin
            r = '0;
            r.found = 1'b1;
            r.cell_number = i[5:0];
            r.full_x = best_rec[i].full_x;
            r.full_y = best_rec[i].full_y;
            r.best_level = best_rec[i].level;
            r.best_score = best_rec[i].score;
            r.last = (i == last_k);
            finish_q = {finish_q, r};
          end
        end
        if (last_k < 0) begin
          r = '0;
          r.last = 1'b1;
          finish_q = {finish_q, r};
        end
        for (int i = 0; i < MAX_CELLS; i++) begin
          occupied[i] = 1'b0;
          has_best[i] = 1'b0;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  task automatic check_result();
    result_t want;
    if (finish_q.size() == 0) begin
      $error("result with no request waiting for it: cell_number %0d", cell_number_i);
      fails++;
    end else begin
      want = finish_q.pop_front();
      check_field("found", want.found, found_i);
      check_field("cell_number", want.cell_number, cell_number_i);
      check_field("full_x", want.full_x, full_x_i);
      check_field("full_y", want.full_y, full_y_i);
      check_field("best_level", want.best_level, best_level_i);
      check_field("best_score", want.best_score, best_score_i);
      check_field("last", want.last, last_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.cell_pixels = RST_CELL_PIXELS;
      regs.grid_columns = RST_GRID_COLUMNS;
      regs.grid_rows_used = RST_GRID_ROWS_USED;
      regs.score_threshold = RST_SCORE_THRESHOLD;
      for (int i = 0; i < MAX_CELLS; i++) begin
        occupied[i] = 1'b0;
        has_best[i] = 1'b0;
        best_rec[i] = '0;
      end
      finish_q.delete();
      fails = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_CELL_PIXELS:     regs.cell_pixels = cfg_data_i[7:0];
          CFG_GRID_COLUMNS:    regs.grid_columns = cfg_data_i[3:0];
          CFG_GRID_ROWS_USED:  regs.grid_rows_used = cfg_data_i[3:0];
          CFG_SCORE_THRESHOLD: regs.score_threshold = cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        take_request(func_i, pos_x_i, pos_y_i, pyr_level_i, corner_score_i);
      end
      if (out_valid_i && !out_stall_i) check_result();
      pending_o <= finish_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

[tb/tb.sv]
// Testbench top for the grid bucket best corner block: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gbbc_pkg::*;

  localparam int IDLE_WAIT = 200;
  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  func_i = '0;
  logic [11:0] pos_x_i = '0;
  logic [11:0] pos_y_i = '0;
  logic [1:0]  pyr_level_i = '0;
  logic [31:0] corner_score_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        found_o;
  logic [5:0]  cell_number_o;
  logic [14:0] full_x_o;
  logic [14:0] full_y_o;
  logic [1:0]  best_level_o;
  logic [31:0] best_score_o;
  logic        last_o;

  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          quiet_cycles = 0;
  logic        quiet;
  logic [31:0] cur_thr;

  grid_bucket_best_corner dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .func_i, .pos_x_i, .pos_y_i, .pyr_level_i, .corner_score_i,
    .out_valid_o, .out_stall_i, .found_o, .cell_number_o, .full_x_o, .full_y_o,
    .best_level_o, .best_score_o, .last_o
  );

  gbbc_checker #(.MAX_CELLS(64)) bucket_check (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .func_i, .pos_x_i, .pos_y_i, .pyr_level_i,
    .corner_score_i, .out_valid_i(out_valid_o), .out_stall_i, .found_i(found_o),
    .cell_number_i(cell_number_o), .full_x_i(full_x_o), .full_y_i(full_y_o),
    .best_level_i(best_level_o), .best_score_i(best_score_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  assign quiet = cycle_count >= 3000 && cycle_count < 6000;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    out_stall_i <= rst_ni && !quiet && ($urandom_range(0, 99) < 17);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(func_e f, logic [11:0] x, logic [11:0] y, logic [1:0] lvl,
                      logic [31:0] score);
    while (!quiet && $urandom_range(0, 99) < 17) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    pos_x_i <= x;
    pos_y_i <= y;
    pyr_level_i <= lvl;
    corner_score_i <= score;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (IDLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] index, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned cp, int unsigned cols, int unsigned rows,
                           logic [31:0] thr, int n);
    int unsigned span_x;
    int unsigned span_y;
    int unsigned fx;
    int unsigned fy;
    int unsigned sel;
    int          gap;
    logic [1:0]  lvl;
    logic [31:0] sc;
    wait_drained();
    write_reg(CFG_CELL_PIXELS, cp);
    write_reg(CFG_GRID_COLUMNS, cols);
    write_reg(CFG_GRID_ROWS_USED, rows);
    write_reg(CFG_SCORE_THRESHOLD, thr);
    cur_thr = thr;
    span_x = (cp == 0) ? 4095 : cp * (cols + 1);
    span_y = (cp == 0) ? 4095 : cp * (rows + 1);
    if (span_x > 4095) span_x = 4095;
    if (span_y > 4095) span_y = 4095;
    gap = $urandom_range(3, 12);
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (i == n - 1 || gap == 0) begin
        send(FUNC_FINISH, 12'($urandom), 12'($urandom), 2'($urandom), $urandom);
        gap = $urandom_range(3, 12);
      end else if (sel < 10) begin
        send(func_e'($urandom_range(0, 3)), 12'($urandom), 12'($urandom), 2'($urandom),
             $urandom);
        gap--;
      end else begin
        fx = $urandom_range(0, span_x);
        fy = $urandom_range(0, span_y);
        lvl = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
          0: sc = $urandom;
          1: begin
            sc = cur_thr + $urandom_range(0, 2);
            if (sc < cur_thr) sc = 32'hFFFF_FFFF;
          end
          2: begin
            sc = cur_thr - $urandom_range(0, 2);
            if (sc > cur_thr) sc = 32'h0;
          end
          default: sc = cur_thr + $urandom_range(3, 5000);
        endcase
        if (sel < 25) send(FUNC_FLAG, 12'(fx), 12'(fy), lvl, sc);
        else send(FUNC_CAND, 12'(fx >> lvl), 12'(fy >> lvl), lvl, sc);
        gap--;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: cells of 30 pixels, 8 by 8, threshold 12800.
    send(FUNC_FLAG, 12'd0, 12'd0, 2'd0, 32'd0);
    send(FUNC_CAND, 12'd5, 12'd5, 2'd0, 32'hFFFF_FFFF);
    send(FUNC_CAND, 12'd30, 12'd0, 2'd0, 32'd12801);
    send(FUNC_CAND, 12'd31, 12'd1, 2'd0, 32'd12801);
    send(FUNC_CAND, 12'd15, 12'd0, 2'd1, 32'd20000);
    send(FUNC_CAND, 12'd60, 12'd0, 2'd0, 32'd12800);
    send(FUNC_CAND, 12'd29, 12'd29, 2'd3, 32'hFFFF_FFFF);
    send(FUNC_CAND, 12'hFFF, 12'hFFF, 2'd3, 32'hFFFF_FFFF);
    send(FUNC_FLAG, 12'hFFF, 12'hFFF, 2'd3, 32'hFFFF_FFFF);
    send(FUNC_CAND, 12'd8, 12'd15, 2'd2, 32'd14000);
    send(FUNC_FLAG, 12'd239, 12'd0, 2'd0, 32'd0);
    send(FUNC_CAND, 12'd239, 12'd0, 2'd0, 32'hFFFF_FFFF);
    send(FUNC_CAND, 12'd240, 12'd0, 2'd0, 32'hFFFF_FFFF);
    send(FUNC_NONE, 12'hFFF, 12'hFFF, 2'd3, 32'hFFFF_FFFF);
    send(FUNC_FINISH, 12'd0, 12'd0, 2'd0, 32'd0);
    send(FUNC_FINISH, 12'hFFF, 12'hFFF, 2'd3, 32'hFFFF_FFFF);
    send(FUNC_CAND, 12'd0, 12'd0, 2'd0, 32'd0);
    send(FUNC_CAND, 12'd0, 12'd0, 2'd0, 32'd13000);
    send(FUNC_FINISH, 12'd0, 12'd0, 2'd0, 32'd0);

    run_phase(30, 8, 8, 32'd12800, 50);
    run_phase(1, 1, 1, 32'd0, 45);
    run_phase(255, 8, 8, 32'hFFFF_FFFF, 40);
    run_phase(7, 8, 8, 32'd0, 55);
    run_phase(100, 3, 5, 32'h0010_0000, 50);
    run_phase(16, 15, 15, 32'd1000, 55);
    run_phase(0, 8, 8, 32'd0, 30);
    run_phase(40, 8, 8, 32'd12800, 70);
    run_phase(3, 2, 8, 32'h8000_0000, 45);

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/gbbc_pkg.sv
sv/gbbc_front.sv
sv/gbbc_back.sv
sv/grid_bucket_best_corner.sv
tb/gbbc_checker.sv
tb/tb.sv
